// ----- rtl/scs_pkg.sv -----
// Shared types and constants of the Annex B start code scanner.
// Used by the front, the queue, the back and the top level.
package scs_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int Q_DEPTH         = 2;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [31:0] START_CODE    = 32'h0000_0001;
    localparam logic [4:0]  NAL_TYPE_MIN  = 5'd1;
    localparam logic [4:0]  NAL_TYPE_MAX  = 5'd12;
    localparam logic [4:0]  NAL_TYPE_SPS  = 5'd7;
    localparam logic [4:0]  NAL_TYPE_IDR  = 5'd5;

    localparam logic [31:0] MAX_SCAN_RST  = 32'd2097152000;
    localparam logic [31:0] GAP_LIMIT_RST = 32'd2162556;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SCAN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        STOP_END  = 2'd0,
        STOP_SCAN = 2'd1,
        STOP_GAP  = 2'd2
    } t_stop_reason;

    typedef struct packed {
        logic start;
        logic last;
        logic valid_nal;
        logic sps;
        logic idr;
    } t_cls;

endpackage

// ----- rtl/scs_front.sv -----
// Front end: accepts bytes, tracks the four-byte window and classifies
// NAL headers. Depends on scs_pkg; pushes into scs_fifo.
module scs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_data_byte,
    input  logic          i_start_flag,
    input  logic          i_end_flag,
    input  logic          i_q_full,
    output logic          o_push,
    output scs_pkg::t_cls o_cls
);
    import scs_pkg::*;

    logic [31:0] r_recent;
    logic [31:0] n_recent;
    logic [31:0] window;
    logic [4:0]  hdr_type;
    logic        hdr_ok;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        window   = i_start_flag ? '1 : r_recent;
        hdr_type = i_data_byte[4:0];
        hdr_ok   = (window == START_CODE) && (hdr_type >= NAL_TYPE_MIN)
                   && (hdr_type <= NAL_TYPE_MAX);
        n_recent = {window[23:0], i_data_byte};
        o_cls.start     = i_start_flag;
        o_cls.last      = i_end_flag;
        o_cls.valid_nal = hdr_ok;
        o_cls.sps       = hdr_ok && (hdr_type == NAL_TYPE_SPS);
        o_cls.idr       = hdr_ok && (hdr_type == NAL_TYPE_IDR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '1;
        end else if (o_push) begin
            r_recent <= n_recent;
        end
    end

endmodule

// ----- rtl/scs_fifo.sv -----
// Short queue of classified bytes between front and back.
// Depends on scs_pkg for the entry type and depth.
module scs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scs_pkg::t_cls i_wdata,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output scs_pkg::t_cls o_rdata
);
    import scs_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cls          r_mem [Q_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wp;
    logic [AW-1:0] n_rp;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp = (r_wp == AW'(Q_DEPTH - 1)) ? '0 : r_wp + AW'(1);
        n_rp = (r_rp == AW'(Q_DEPTH - 1)) ? '0 : r_rp + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/scs_back.sv -----
// Back end: scan state, offset and gap counters, stop tests and the
// result register; holds the configuration registers. Depends on scs_pkg.
module scs_back #(
    parameter int OFFSET_BITS = scs_pkg::OFFSET_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [scs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [scs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_q_valid,
    input  scs_pkg::t_cls                      i_cls,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [31:0]                        o_carved_size,
    output logic                               o_saw_sps,
    output logic                               o_saw_idr,
    output logic [1:0]                         o_stop_reason
);
    import scs_pkg::*;

    localparam int CW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    logic [31:0]            r_max_scan;
    logic [31:0]            r_gap_limit;
    logic                   r_active;
    logic [OFFSET_BITS-1:0] r_off;
    logic [OFFSET_BITS-1:0] r_gap;
    logic [OFFSET_BITS-1:0] r_last;
    logic                   r_sps;
    logic                   r_idr;
    logic                   r_out_valid;
    logic [31:0]            r_carved;
    logic                   r_out_sps;
    logic                   r_out_idr;
    t_stop_reason           r_reason;

    logic                   act;
    logic [OFFSET_BITS-1:0] off_base;
    logic [OFFSET_BITS-1:0] gap_base;
    logic [OFFSET_BITS-1:0] last_base;
    logic [OFFSET_BITS-1:0] n_off;
    logic [OFFSET_BITS-1:0] n_gap;
    logic [OFFSET_BITS-1:0] n_last;
    logic                   n_sps;
    logic                   n_idr;
    logic [CW-1:0]          e_last;
    logic                   hit_max;
    logic                   hit_gap;
    logic                   stop;
    t_stop_reason           n_reason;
    logic                   take;

    assign o_cfg_ready   = 1'b1;
    assign o_pop         = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid   = r_out_valid;
    assign o_carved_size = r_carved;
    assign o_saw_sps     = r_out_sps;
    assign o_saw_idr     = r_out_idr;
    assign o_stop_reason = r_reason;

    always_comb begin
        act       = i_cls.start || r_active;
        off_base  = i_cls.start ? '0 : r_off;
        gap_base  = i_cls.start ? '0 : r_gap;
        last_base = i_cls.start ? '0 : r_last;
        n_sps     = (!i_cls.start && r_sps) || i_cls.sps;
        n_idr     = (!i_cls.start && r_idr) || i_cls.idr;
        n_off     = (off_base == '1) ? off_base : off_base + OFFSET_BITS'(1);
        n_gap     = i_cls.valid_nal ? '0 : gap_base + OFFSET_BITS'(1);
        n_last    = i_cls.valid_nal ? off_base + OFFSET_BITS'(1) : last_base;
        e_last    = CW'(n_last);
        hit_max   = (CW'(n_off) >= CW'(r_max_scan)) || (n_off == '1);
        hit_gap   = CW'(n_gap) > CW'(r_gap_limit);
        stop      = i_cls.last || hit_max || hit_gap;
        priority if (i_cls.last) begin
            n_reason = STOP_END;
        end else if (hit_max) begin
            n_reason = STOP_SCAN;
        end else begin
            n_reason = STOP_GAP;
        end
        take = o_pop && act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_scan  <= MAX_SCAN_RST;
            r_gap_limit <= GAP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_SCAN:  r_max_scan  <= i_cfg_data;
                CFG_GAP_LIMIT: r_gap_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_off       <= '0;
            r_gap       <= '0;
            r_last      <= '0;
            r_sps       <= 1'b0;
            r_idr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_active <= !stop;
                r_off    <= n_off;
                r_gap    <= n_gap;
                r_last   <= n_last;
                r_sps    <= n_sps;
                r_idr    <= n_idr;
            end
            if (take && stop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && stop) begin
            r_carved  <= (n_sps && n_idr) ? e_last[31:0] : 32'd0;
            r_out_sps <= n_sps;
            r_out_idr <= n_idr;
            r_reason  <= n_reason;
        end
    end

    a_carve_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_carved != 32'd0) |-> r_out_sps && r_out_idr)
        else $error("carved size without SPS and IDR");

    a_gap_within_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_gap <= r_off))
        else $error("gap counter exceeds offset");

    a_stop_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && stop |=> !r_active && r_out_valid)
        else $error("scan still active after stop");

    a_no_pop_on_stalled_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !o_pop)
        else $error("queue popped while result stalled");

endmodule

// ----- rtl/h264_start_code_carve_scanner.sv -----
// Annex B start code scanner for carving: one byte per cycle, save under stall.
// The back end registers a result when it takes the byte that stops the scan.
// Throughput: one byte per cycle through a two-entry queue; the back end
// holds the queue only while a finished result waits under stall.
// Reset: synchronous, active low; scan idle, queue empty, registers at defaults.
module h264_start_code_carve_scanner #(
    parameter int OFFSET_BITS = scs_pkg::OFFSET_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_start_flag,
    input  logic                               i_end_flag,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [31:0]                        o_carved_size,
    output logic                               o_saw_sps,
    output logic                               o_saw_idr,
    output logic [1:0]                         o_stop_reason,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [scs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [scs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import scs_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_cls w_cls;
    t_cls r_cls;

    scs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_start_flag (i_start_flag),
        .i_end_flag   (i_end_flag),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cls        (w_cls)
    );

    scs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (w_cls),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_rdata (r_cls)
    );

    scs_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_cls         (r_cls),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_carved_size (o_carved_size),
        .o_saw_sps     (o_saw_sps),
        .o_saw_idr     (o_saw_idr),
        .o_stop_reason (o_stop_reason)
    );

endmodule
